[rtl/pdc_pkg.sv]
// Shared types and constants of the power-diagram polygon clipper.
// Used by the channel interfaces and by every module of the block; no dependencies.
package pdc_pkg;

    // Field widths.
    localparam int COORD_W   = 18;  // signed fixed-point coordinate
    localparam int WEIGHT_W  = 40;  // signed fixed-point power weight
    localparam int PDIFF_W   = 44;  // signed power difference, squared scale
    localparam int CFG_IDX_W = 3;

    // Datapath widths of the crossing computation.
    localparam int DMAG_W = COORD_W;            // magnitude of a coordinate difference
    localparam int FMAG_W = 42;                 // magnitude of f and of the f difference
    localparam int FLO_W  = FMAG_W / 2;         // low slice of the split multiply
    localparam int FHI_W  = FMAG_W - FLO_W;     // high slice of the split multiply
    localparam int NUM_W  = FMAG_W + DMAG_W;    // magnitude of the numerator
    localparam int QUO_W  = COORD_W + 1;        // quotient bits produced per division
    localparam int DIVD_W = NUM_W + 2;          // rounded dividend 2n + d
    localparam int REM_W  = DIVD_W - QUO_W;     // partial remainder
    localparam int SUM_W  = QUO_W + 2;          // coordinate plus signed offset

    // Command queue between front and back.
    localparam int DEF_QUEUE_DEPTH = 4;
    localparam int NUM_SLOTS       = 5;          // results one vertex may schedule

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SITE_A_X   = 3'd0,
        CFG_SITE_A_Y   = 3'd1,
        CFG_WEIGHT_A   = 3'd2,
        CFG_SITE_B_X   = 3'd3,
        CFG_SITE_B_Y   = 3'd4,
        CFG_WEIGHT_B   = 3'd5
    } t_cfg_idx;

    // Site configuration as seen by the front.
    typedef struct packed {
        logic signed [COORD_W-1:0]  ax;
        logic signed [COORD_W-1:0]  ay;
        logic signed [WEIGHT_W-1:0] wa;
        logic signed [COORD_W-1:0]  bx;
        logic signed [COORD_W-1:0]  by;
        logic signed [WEIGHT_W-1:0] wb;
    } t_sites;

    // Kind of result a queued command produces.
    typedef enum logic [1:0] {
        CMD_CROSS,
        CMD_VERT,
        CMD_EMPTY
    } t_cmd_kind;

    // One queued result command. A vertex command uses cx and cy only.
    typedef struct packed {
        t_cmd_kind                  kind;
        logic                       eop;
        logic signed [COORD_W-1:0]  px;
        logic signed [COORD_W-1:0]  py;
        logic signed [PDIFF_W-1:0]  fp;
        logic signed [COORD_W-1:0]  cx;
        logic signed [COORD_W-1:0]  cy;
        logic signed [PDIFF_W-1:0]  fc;
    } t_cmd;

    typedef enum logic [1:0] {
        F_IDLE,
        F_POWER,
        F_CLASS,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SETUP,
        B_MUL_LO,
        B_MUL_HI,
        B_DIV_INIT,
        B_DIV,
        B_DONE,
        B_EMIT
    } t_back_state;

endpackage

[rtl/pdc_vert_if.sv]
// Input vertex channel of the polygon clipper.
// Depends on pdc_pkg for the field widths.
interface pdc_vert_if import pdc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] vert_x;
    logic signed [COORD_W-1:0] vert_y;
    logic                      last_vertex;

    modport source (output valid, vert_x, vert_y, last_vertex, input ready);
    modport sink   (input valid, vert_x, vert_y, last_vertex, output ready);
endinterface

[rtl/pdc_cfg_if.sv]
// Configuration write channel of the polygon clipper.
// Depends on pdc_pkg for the index and data widths.
interface pdc_cfg_if import pdc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [WEIGHT_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/pdc_res_if.sv]
// Result channel of the polygon clipper.
// Depends on pdc_pkg for the field widths.
interface pdc_res_if import pdc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic                      vertex_valid;
    logic                      end_of_polygon;

    modport source (output valid, out_x, out_y, vertex_valid, end_of_polygon, input ready);
    modport sink   (input valid, out_x, out_y, vertex_valid, end_of_polygon, output ready);
endinterface

[rtl/pdc_front.sv]
// Front of the clipper: accepts vertices, computes the power difference and
// schedules the results of each vertex as commands. Depends on pdc_pkg, pdc_vert_if.
module pdc_front import pdc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pdc_vert_if.sink   i_vert,
    input  t_sites     i_sites,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam logic [2:0] LAST_STEP = 3'd4;

    t_front_state r_state, n_state;

    logic [2:0]                 r_step;
    logic [NUM_SLOTS-1:0]       r_mask;
    logic [2:0]                 r_slot;
    logic                       r_have_first;

    logic signed [COORD_W-1:0]  r_vx, r_vy;
    logic                       r_last;
    logic signed [PDIFF_W-1:0]  r_acc;
    logic [DMAG_W-1:0]          r_mag;
    logic signed [COORD_W-1:0]  r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic signed [PDIFF_W-1:0]  r_first_f, r_prev_f;
    logic signed [COORD_W-1:0]  r_ep_x, r_ep_y, r_ef_x, r_ef_y;
    logic signed [PDIFF_W-1:0]  r_ep_f, r_ef_f;

    logic signed [COORD_W:0]    w_diff, w_diff_neg;
    logic [DMAG_W-1:0]          w_mag;
    logic [2*DMAG_W-1:0]        w_sq;
    logic signed [PDIFF_W-1:0]  w_sq_ext, w_acc_init;
    logic                       w_sub;
    logic                       w_cin, w_pin, w_fin;
    logic signed [COORD_W-1:0]  w_fx, w_fy;
    logic signed [PDIFF_W-1:0]  w_ff;
    logic [NUM_SLOTS-1:0]       w_mask;
    logic                       w_vert_xfer, w_advance, w_done;

    // Coordinate difference for the current power step and its magnitude.
    always_comb begin
        unique case (r_step[1:0])
            2'd0:    w_diff = {r_vx[COORD_W-1], r_vx} - {i_sites.ax[COORD_W-1], i_sites.ax};
            2'd1:    w_diff = {r_vy[COORD_W-1], r_vy} - {i_sites.ay[COORD_W-1], i_sites.ay};
            2'd2:    w_diff = {r_vx[COORD_W-1], r_vx} - {i_sites.bx[COORD_W-1], i_sites.bx};
            default: w_diff = {r_vy[COORD_W-1], r_vy} - {i_sites.by[COORD_W-1], i_sites.by};
        endcase
    end

    assign w_diff_neg = -w_diff;
    assign w_mag      = w_diff[COORD_W] ? w_diff_neg[DMAG_W-1:0] : w_diff[DMAG_W-1:0];

    // One shared squarer; the last two squares belong to site b and are subtracted.
    assign w_sq       = r_mag * r_mag;
    assign w_sq_ext   = {{(PDIFF_W-2*DMAG_W){1'b0}}, w_sq};
    assign w_sub      = (r_step == 3'd3) || (r_step == LAST_STEP);
    assign w_acc_init = {{(PDIFF_W-WEIGHT_W){i_sites.wb[WEIGHT_W-1]}}, i_sites.wb}
                      - {{(PDIFF_W-WEIGHT_W){i_sites.wa[WEIGHT_W-1]}}, i_sites.wa};

    // Side tests: a point is inside when its power difference is not positive.
    assign w_fx  = r_have_first ? r_first_x : r_vx;
    assign w_fy  = r_have_first ? r_first_y : r_vy;
    assign w_ff  = r_have_first ? r_first_f : r_acc;
    assign w_cin = r_acc[PDIFF_W-1] || (r_acc == '0);
    assign w_pin = r_prev_f[PDIFF_W-1] || (r_prev_f == '0);
    assign w_fin = w_ff[PDIFF_W-1] || (w_ff == '0);

    // Result slots in output order: edge crossing, current vertex, closing
    // crossing, first vertex, empty end marker.
    always_comb begin
        w_mask[0] = r_have_first && (w_pin != w_cin);
        w_mask[1] = r_have_first && w_cin;
        w_mask[2] = r_last && (w_cin != w_fin);
        w_mask[3] = r_last && w_fin;
        w_mask[4] = r_last && (w_mask[3:0] == '0);
    end

    // Command for the slot being pushed.
    always_comb begin
        o_cmd      = '0;
        o_cmd.kind = CMD_EMPTY;
        o_cmd.eop  = r_last && (r_mask[NUM_SLOTS-1:1] == '0);
        unique case (r_slot)
            3'd0: begin
                o_cmd.kind = CMD_CROSS;
                o_cmd.px   = r_ep_x;
                o_cmd.py   = r_ep_y;
                o_cmd.fp   = r_ep_f;
                o_cmd.cx   = r_vx;
                o_cmd.cy   = r_vy;
                o_cmd.fc   = r_acc;
            end
            3'd1: begin
                o_cmd.kind = CMD_VERT;
                o_cmd.cx   = r_vx;
                o_cmd.cy   = r_vy;
            end
            3'd2: begin
                o_cmd.kind = CMD_CROSS;
                o_cmd.px   = r_vx;
                o_cmd.py   = r_vy;
                o_cmd.fp   = r_acc;
                o_cmd.cx   = r_ef_x;
                o_cmd.cy   = r_ef_y;
                o_cmd.fc   = r_ef_f;
            end
            3'd3: begin
                o_cmd.kind = CMD_VERT;
                o_cmd.cx   = r_ef_x;
                o_cmd.cy   = r_ef_y;
            end
            default: begin
                o_cmd.kind = CMD_EMPTY;
            end
        endcase
    end

    assign w_vert_xfer = i_vert.valid && i_vert.ready;
    assign w_advance   = !r_mask[0] || !i_full;
    assign w_done      = r_mask[NUM_SLOTS-1:1] == '0;

    // Next state and handshake outputs.
    always_comb begin
        n_state      = r_state;
        i_vert.ready = 1'b0;
        o_push       = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                i_vert.ready = 1'b1;
                if (i_vert.valid) begin
                    n_state = F_POWER;
                end
            end
            F_POWER: begin
                if (r_step == LAST_STEP) begin
                    n_state = F_CLASS;
                end
            end
            F_CLASS: begin
                n_state = (w_mask == '0) ? F_IDLE : F_PUSH;
            end
            F_PUSH: begin
                o_push = r_mask[0] && !i_full;
                if (w_advance && w_done) begin
                    n_state = F_IDLE;
                end
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= F_IDLE;
            r_step       <= '0;
            r_mask       <= '0;
            r_slot       <= '0;
            r_have_first <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                F_IDLE: begin
                    r_step <= '0;
                end
                F_POWER: begin
                    r_step <= r_step + 3'd1;
                end
                F_CLASS: begin
                    r_mask       <= w_mask;
                    r_slot       <= '0;
                    r_have_first <= !r_last;
                end
                F_PUSH: begin
                    if (w_advance) begin
                        r_mask <= r_mask >> 1;
                        r_slot <= r_slot + 3'd1;
                    end
                end
            endcase
        end
    end

    // Vertex, power difference and polygon state.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_IDLE: begin
                if (w_vert_xfer) begin
                    r_vx   <= i_vert.vert_x;
                    r_vy   <= i_vert.vert_y;
                    r_last <= i_vert.last_vertex;
                    r_acc  <= w_acc_init;
                end
            end
            F_POWER: begin
                if (r_step != LAST_STEP) begin
                    r_mag <= w_mag;
                end
                if (r_step != 3'd0) begin
                    r_acc <= w_sub ? (r_acc - w_sq_ext) : (r_acc + w_sq_ext);
                end
            end
            F_CLASS: begin
                r_ep_x   <= r_prev_x;
                r_ep_y   <= r_prev_y;
                r_ep_f   <= r_prev_f;
                r_ef_x   <= w_fx;
                r_ef_y   <= w_fy;
                r_ef_f   <= w_ff;
                r_prev_x <= r_vx;
                r_prev_y <= r_vy;
                r_prev_f <= r_acc;
                if (!r_have_first) begin
                    r_first_x <= r_vx;
                    r_first_y <= r_vy;
                    r_first_f <= r_acc;
                end
            end
            F_PUSH: begin
            end
        endcase
    end

`ifndef ASSERT_OFF
    // A push sequence always has at least one result slot left to handle.
    a_push_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == F_PUSH |-> r_mask != '0)
        else $error("front in push state with no scheduled result");
`endif

endmodule

[rtl/pdc_queue.sv]
// Command queue that decouples the front from the back of the clipper.
// Depends on pdc_pkg for the command type.
module pdc_queue import pdc_pkg::*; #(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push_ok, w_pop_ok;

    assign o_full    = r_count == CNT_W'(DEPTH);
    assign o_empty   = r_count == '0;
    assign o_head    = r_mem[r_rd];
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_pop && !o_empty;

    // Fill level.
    always_comb begin
        unique case ({w_push_ok, w_pop_ok})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (w_push_ok) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_pop_ok) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

`ifndef ASSERT_OFF
    // The front never offers a command the queue cannot take.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command pushed into a full queue");

    // The back only pops a command that is there.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("command popped from an empty queue");

    // Fill level stays within the storage.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill level beyond depth");
`endif

endmodule

[rtl/pdc_back.sv]
// Back of the clipper: executes queued commands, computing crossing points with
// a split multiplier and a shared radix-2 divider. Depends on pdc_pkg, pdc_res_if.
module pdc_back import pdc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cmd       i_head,
    output logic       o_pop,
    pdc_res_if.source  o_res
);

    localparam int CNT_W = $clog2(QUO_W);

    t_back_state r_state, n_state;

    t_cmd                       r_cmd;
    logic                       r_axis;
    logic [FMAG_W-1:0]          r_fpmag, r_dmag;
    logic                       r_fp_neg, r_den_neg, r_qneg;
    logic signed [COORD_W-1:0]  r_p;
    logic [DMAG_W-1:0]          r_dfmag;
    logic [NUM_W-1:0]           r_num;
    logic [REM_W-1:0]           r_rem;
    logic [QUO_W-1:0]           r_quo;
    logic [CNT_W-1:0]           r_cnt;
    logic signed [COORD_W-1:0]  r_res_x, r_ex, r_ey;
    logic                       r_evalid, r_eeop;
    logic                       r_ov, r_ovv, r_oeop;
    logic signed [COORD_W-1:0]  r_ox, r_oy;

    logic signed [PDIFF_W:0]    w_den, w_den_neg;
    logic signed [PDIFF_W-1:0]  w_fp_neg_val;
    logic signed [COORD_W-1:0]  w_p, w_c;
    logic signed [COORD_W:0]    w_diff, w_diff_neg;
    logic [FLO_W+DMAG_W-1:0]    w_plo;
    logic [FHI_W+DMAG_W-1:0]    w_phi;
    logic [DIVD_W-1:0]          w_divd;
    logic [REM_W:0]             w_trial, w_dsr, w_rsub;
    logic                       w_ge;
    logic signed [SUM_W-1:0]    w_p_ext, w_q_ext, w_sum;
    logic [SUM_W-COORD_W:0]     w_sum_hi;
    logic signed [COORD_W-1:0]  w_sat;
    logic                       w_slot_free;

    // Divisor f(prev) - f(cur) and magnitudes taken when a command is popped.
    assign w_den        = {i_head.fp[PDIFF_W-1], i_head.fp} - {i_head.fc[PDIFF_W-1], i_head.fc};
    assign w_den_neg    = -w_den;
    assign w_fp_neg_val = -i_head.fp;

    // Endpoints of the axis in work and their difference.
    assign w_p        = r_axis ? r_cmd.py : r_cmd.px;
    assign w_c        = r_axis ? r_cmd.cy : r_cmd.cx;
    assign w_diff     = {w_c[COORD_W-1], w_c} - {w_p[COORD_W-1], w_p};
    assign w_diff_neg = -w_diff;

    // Numerator magnitude as two partial products, in B_MUL_LO and then B_MUL_HI.
    assign w_plo = r_fpmag[FLO_W-1:0] * r_dfmag;
    assign w_phi = r_fpmag[FMAG_W-1:FLO_W] * r_dfmag;

    // Rounded quotient (2n + d) / 2d; the quotient fits QUO_W bits, so the
    // upper dividend bits start as the partial remainder.
    assign w_divd  = {1'b0, r_num, 1'b0} + {{(DIVD_W-FMAG_W){1'b0}}, r_dmag};
    assign w_trial = {r_rem, r_quo[QUO_W-1]};
    assign w_dsr   = {1'b0, r_dmag, 1'b0};
    assign w_ge    = w_trial >= w_dsr;
    assign w_rsub  = w_trial - w_dsr;

    // Apply the signed offset and saturate to the coordinate range.
    assign w_p_ext  = {{(SUM_W-COORD_W){r_p[COORD_W-1]}}, r_p};
    assign w_q_ext  = {{(SUM_W-QUO_W){1'b0}}, r_quo};
    assign w_sum    = r_qneg ? (w_p_ext - w_q_ext) : (w_p_ext + w_q_ext);
    assign w_sum_hi = w_sum[SUM_W-1:COORD_W-1];

    always_comb begin
        if ((w_sum_hi == '0) || (w_sum_hi == '1)) begin
            w_sat = w_sum[COORD_W-1:0];
        end else if (w_sum[SUM_W-1]) begin
            w_sat = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(COORD_W-1){1'b1}}};
        end
    end

    assign w_slot_free = !r_ov || o_res.ready;

    // Next state and queue pop.
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = (i_head.kind == CMD_CROSS) ? B_SETUP : B_EMIT;
                end
            end
            B_SETUP:    n_state = B_MUL_LO;
            B_MUL_LO:   n_state = B_MUL_HI;
            B_MUL_HI:   n_state = B_DIV_INIT;
            B_DIV_INIT: n_state = B_DIV;
            B_DIV: begin
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    n_state = B_DONE;
                end
            end
            B_DONE: begin
                n_state = r_axis ? B_EMIT : B_SETUP;
            end
            B_EMIT: begin
                if (w_slot_free) begin
                    n_state = B_IDLE;
                end
            end
        endcase
    end

    // Control registers: state, axis, step count and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_axis  <= 1'b0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_IDLE) begin
                r_axis <= 1'b0;
            end else if (r_state == B_DONE) begin
                r_axis <= 1'b1;
            end
            if (r_state == B_DIV_INIT) begin
                r_cnt <= '0;
            end else if (r_state == B_DIV) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if ((r_state == B_EMIT) && w_slot_free) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    r_cmd     <= i_head;
                    r_den_neg <= w_den[PDIFF_W];
                    r_dmag    <= w_den[PDIFF_W] ? w_den_neg[FMAG_W-1:0] : w_den[FMAG_W-1:0];
                    r_fp_neg  <= i_head.fp[PDIFF_W-1];
                    r_fpmag   <= i_head.fp[PDIFF_W-1] ? w_fp_neg_val[FMAG_W-1:0]
                                                      : i_head.fp[FMAG_W-1:0];
                    r_ex      <= (i_head.kind == CMD_VERT) ? i_head.cx : '0;
                    r_ey      <= (i_head.kind == CMD_VERT) ? i_head.cy : '0;
                    r_evalid  <= i_head.kind == CMD_VERT;
                    r_eeop    <= i_head.eop;
                end
            end
            B_SETUP: begin
                r_p     <= w_p;
                r_dfmag <= w_diff[COORD_W] ? w_diff_neg[DMAG_W-1:0] : w_diff[DMAG_W-1:0];
                r_qneg  <= r_fp_neg ^ w_diff[COORD_W] ^ r_den_neg;
            end
            B_MUL_LO: begin
                r_num <= {{(NUM_W-FLO_W-DMAG_W){1'b0}}, w_plo};
            end
            B_MUL_HI: begin
                r_num <= r_num + {w_phi, {FLO_W{1'b0}}};
            end
            B_DIV_INIT: begin
                r_rem <= w_divd[DIVD_W-1:QUO_W];
                r_quo <= w_divd[QUO_W-1:0];
            end
            B_DIV: begin
                r_rem <= w_ge ? w_rsub[REM_W-1:0] : w_trial[REM_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], w_ge};
            end
            B_DONE: begin
                if (!r_axis) begin
                    r_res_x <= w_sat;
                end else begin
                    r_ex     <= r_res_x;
                    r_ey     <= w_sat;
                    r_evalid <= 1'b1;
                    r_eeop   <= r_cmd.eop;
                end
            end
            B_EMIT: begin
                if (w_slot_free) begin
                    r_ox   <= r_ex;
                    r_oy   <= r_ey;
                    r_ovv  <= r_evalid;
                    r_oeop <= r_eeop;
                end
            end
        endcase
    end

    // Output register drives the result channel.
    assign o_res.valid          = r_ov;
    assign o_res.out_x          = r_ox;
    assign o_res.out_y          = r_oy;
    assign o_res.vertex_valid   = r_ovv;
    assign o_res.end_of_polygon = r_oeop;

`ifndef ASSERT_OFF
    // The quotient fits its width: the partial remainder stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_DIV |-> r_rem < {r_dmag, 1'b0})
        else $error("divider remainder not below divisor");

    // An empty result is always the end marker at the origin.
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.vertex_valid) |->
            (o_res.end_of_polygon && (o_res.out_x == '0) && (o_res.out_y == '0)))
        else $error("empty result that is not a clean end marker");
`endif

endmodule

[rtl/power_diagram_polygon_clip.sv]
// Top level of the power-diagram polygon clipper: configuration registers, front,
// command queue and back. Depends on pdc_pkg, the channel interfaces and all submodules.
//
// Clips a polygon, fed one vertex per transfer, against the power-diagram half-plane of
// two weighted sites and returns the clipped vertices, the last one flagged end of
// polygon. For each vertex the front takes it, runs five power-difference steps and a
// classify step, then hands the commands of the result slots the vertex uses, in slot
// order, to a 4-entry queue, stalling while the queue is full; it accepts the next vertex
// as soon as its commands are queued. The back sets the rate: a plain vertex or an empty
// end marker goes from the queue straight to the output register, while a crossing point
// takes two 19-step radix-2 divisions on the one shared divider plus a split multiply
// per axis. The back also holds whenever the receiver holds off the result channel.
module power_diagram_polygon_clip import pdc_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pdc_vert_if.sink   i_vert,
    pdc_cfg_if.sink    i_cfg,
    pdc_res_if.source  o_res
);

    t_sites r_sites;
    t_cmd   w_push_cmd, w_head;
    logic   w_push, w_full, w_pop, w_empty;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sites <= '0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_SITE_A_X: r_sites.ax <= i_cfg.data[COORD_W-1:0];
                CFG_SITE_A_Y: r_sites.ay <= i_cfg.data[COORD_W-1:0];
                CFG_WEIGHT_A: r_sites.wa <= i_cfg.data;
                CFG_SITE_B_X: r_sites.bx <= i_cfg.data[COORD_W-1:0];
                CFG_SITE_B_Y: r_sites.by <= i_cfg.data[COORD_W-1:0];
                CFG_WEIGHT_B: r_sites.wb <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    pdc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vert  (i_vert),
        .i_sites (r_sites),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    pdc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    pdc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule

[test/tb.sv]
// Self-checking testbench for power_diagram_polygon_clip: drives polygons and register writes,
// predicts every clipped vertex in its own model and compares the result stream.
// Depends on pdc_pkg, the three channel interfaces and the top level of the block.
module tb;
    import pdc_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_CYCLES = 64;
    localparam int LIMIT_CYCLES = 600000;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 24;
    localparam int IDLE_PCT     = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int FRAC_BITS    = 16;
    localparam int MAX_REPORTS  = 50;

    localparam logic signed [COORD_W-1:0]  C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0]  C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0]  C_ONE = COORD_W'(1 << FRAC_BITS);
    localparam logic signed [COORD_W-1:0]  C_HALF = COORD_W'(1 << (FRAC_BITS - 1));
    localparam logic [WEIGHT_W-1:0]        W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
    localparam logic [WEIGHT_W-1:0]        W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};
    localparam longint                     COORD_HI = (longint'(1) <<< (COORD_W - 1)) - 1;
    localparam longint                     COORD_LO = -(longint'(1) <<< (COORD_W - 1));

    // Register indexes that decode to nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
    } t_vert_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      vld;
        logic                      eop;
    } t_clip_res;

    logic i_clk;
    logic i_rst_n;

    pdc_vert_if vert_if ();
    pdc_cfg_if  cfg_if ();
    pdc_res_if  res_if ();

    power_diagram_polygon_clip u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vert  (vert_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // Predicted block state: site registers and the open polygon.
    t_sites                    pred_sites = '0;
    logic signed [COORD_W-1:0] open_x = '0;
    logic signed [COORD_W-1:0] open_y = '0;
    logic signed [PDIFF_W-1:0] open_pd = '0;
    logic signed [COORD_W-1:0] tail_x = '0;
    logic signed [COORD_W-1:0] tail_y = '0;
    logic signed [PDIFF_W-1:0] tail_pd = '0;
    bit                        poly_open = 1'b0;

    t_vert_item vert_pending_q[$];
    t_clip_res  clip_expect_q[$];

    int  vert_count = 0;
    int  poly_count = 0;
    int  res_count = 0;
    int  cfg_count = 0;
    int  err_count = 0;
    int  hold_left = 0;
    bit  calm = 1'b0;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Power difference of a vertex against the two predicted sites.
    function automatic longint power_gap(input t_sites s, input longint x, input longint y);
        longint ax, ay, bx, by;
        ax = x - longint'($signed(s.ax));
        ay = y - longint'($signed(s.ay));
        bx = x - longint'($signed(s.bx));
        by = y - longint'($signed(s.by));
        return (ax * ax + ay * ay - longint'($signed(s.wa)))
             - (bx * bx + by * by - longint'($signed(s.wb)));
    endfunction

    // One coordinate of the crossing point, rounded half away from zero and saturated.
    function automatic logic signed [COORD_W-1:0] cross_point(input longint p, input longint c,
                                                             input longint pf, input longint cf);
        longint          num, den, pos;
        longint unsigned n, d, q;
        num = pf * (c - p);
        den = pf - cf;
        if (den == 0) begin
            pos = p;
        end else begin
            n = (num < 0) ? -num : num;
            d = (den < 0) ? -den : den;
            q = (2 * n + d) / (2 * d);
            pos = ((num < 0) != (den < 0)) ? p - longint'(q) : p + longint'(q);
        end
        if (pos > COORD_HI) pos = COORD_HI;
        if (pos < COORD_LO) pos = COORD_LO;
        return COORD_W'(pos);
    endfunction

    // Appends one expected result at the tail of the expectation queue.
    task automatic expect_add(input t_clip_res r);
        clip_expect_q.insert(clip_expect_q.size(), r);
    endtask

    // Results of one edge: the crossing when the ends differ in side, then the end if inside.
    task automatic clip_edge(input longint px, input longint py, input longint pf,
                             input longint cx, input longint cy, input longint cf);
        t_clip_res r;
        r.vld = 1'b1;
        r.eop = 1'b0;
        if ((cf <= 0) != (pf <= 0)) begin
            r.x = cross_point(px, cx, pf, cf);
            r.y = cross_point(py, cy, pf, cf);
            expect_add(r);
        end
        if (cf <= 0) begin
            r.x = COORD_W'(cx);
            r.y = COORD_W'(cy);
            expect_add(r);
        end
    endtask

    // Expected results of one accepted vertex.
    task automatic clip_vertex(input logic signed [COORD_W-1:0] vx,
                               input logic signed [COORD_W-1:0] vy, input logic last);
        longint    x, y, f;
        int        base;
        t_clip_res r;
        x = vx;
        y = vy;
        f = power_gap(pred_sites, x, y);
        base = clip_expect_q.size();
        if (!poly_open) begin
            open_x = vx;
            open_y = vy;
            open_pd = PDIFF_W'(f);
            poly_open = 1'b1;
        end else begin
            clip_edge(tail_x, tail_y, tail_pd, x, y, f);
        end
        tail_x = vx;
        tail_y = vy;
        tail_pd = PDIFF_W'(f);
        if (last) begin
            // Closing edge back to the stored first vertex.
            clip_edge(x, y, f, open_x, open_y, open_pd);
            if (clip_expect_q.size() == base) begin
                r = '0;
                expect_add(r);
            end
            r = clip_expect_q.pop_back();
            r.eop = 1'b1;
            expect_add(r);
            poly_open = 1'b0;
            poly_count++;
        end
    endtask

    // Vertex driver: holds an offer until its transfer, then takes the next pending item.
    always @(posedge i_clk) begin : vert_driver
        t_vert_item item;
        if (!i_rst_n) begin
            vert_if.valid <= 1'b0;
        end else begin
            if (vert_if.valid && vert_if.ready) begin
                clip_vertex(vert_if.vert_x, vert_if.vert_y, vert_if.last_vertex);
                vert_count++;
            end
            if (!vert_if.valid || vert_if.ready) begin
                if (vert_pending_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    item = vert_pending_q.pop_front();
                    vert_if.valid       <= 1'b1;
                    vert_if.vert_x      <= item.x;
                    vert_if.vert_y      <= item.y;
                    vert_if.last_vertex <= item.last;
                end else begin
                    vert_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            res_if.ready <= 1'b0;
            hold_left--;
        end else begin
            res_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Result monitor: every transfer is matched against the oldest expectation.
    always @(posedge i_clk) begin : res_monitor
        t_clip_res got, want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.x   = res_if.out_x;
            got.y   = res_if.out_y;
            got.vld = res_if.vertex_valid;
            got.eop = res_if.end_of_polygon;
            res_count++;
            if (clip_expect_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: unexpected result x=%0d y=%0d vld=%0b eop=%0b",
                             $time, got.x, got.y, got.vld, got.eop);
            end else begin
                want = clip_expect_q.pop_front();
                if (got !== want) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: mismatch, expected x=%0d y=%0d vld=%0b eop=%0b, %s%0d %0d %0b %0b",
                                 $time, want.x, want.y, want.vld, want.eop,
                                 "actual x y vld eop = ", got.x, got.y, got.vld, got.eop);
                end
            end
        end
    end

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(9))
            0:       return C_MIN;
            1:       return C_MAX;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // Full-range weights, or ones in the scale of squared distances.
    function automatic logic [WEIGHT_W-1:0] rand_weight(input bit wide);
        logic [63:0] r;
        r = {$urandom, $urandom};
        if (wide) return r[WEIGHT_W-1:0];
        return {{(WEIGHT_W-36){r[35]}}, r[35:0]};
    endfunction

    task automatic push_vert(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y, input logic last);
        t_vert_item item;
        item.x = x;
        item.y = y;
        item.last = last;
        vert_pending_q.insert(vert_pending_q.size(), item);
    endtask

    // One register write; valid stays high so that back-to-back writes need no dip.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_count++;
        case (idx)
            CFG_SITE_A_X: pred_sites.ax = data[COORD_W-1:0];
            CFG_SITE_A_Y: pred_sites.ay = data[COORD_W-1:0];
            CFG_WEIGHT_A: pred_sites.wa = data;
            CFG_SITE_B_X: pred_sites.bx = data[COORD_W-1:0];
            CFG_SITE_B_Y: pred_sites.by = data[COORD_W-1:0];
            CFG_WEIGHT_B: pred_sites.wb = data;
            default: ;
        endcase
    endtask

    // Writes all six site registers; coordinate writes carry junk in the unused upper bits.
    task automatic load_sites(input logic signed [COORD_W-1:0] ax,
                              input logic signed [COORD_W-1:0] ay, input logic [WEIGHT_W-1:0] wa,
                              input logic signed [COORD_W-1:0] bx,
                              input logic signed [COORD_W-1:0] by, input logic [WEIGHT_W-1:0] wb,
                              input bit spare);
        cfg_write(CFG_SITE_A_X, {(WEIGHT_W-COORD_W)'($urandom), ax});
        cfg_write(CFG_SITE_A_Y, {(WEIGHT_W-COORD_W)'($urandom), ay});
        cfg_write(CFG_WEIGHT_A, wa);
        cfg_write(CFG_SITE_B_X, {(WEIGHT_W-COORD_W)'($urandom), bx});
        cfg_write(CFG_SITE_B_Y, {(WEIGHT_W-COORD_W)'($urandom), by});
        cfg_write(CFG_WEIGHT_B, wb);
        if (spare) begin
            cfg_write(CFG_SPARE_A, rand_weight(1'b1));
            cfg_write(CFG_SPARE_B, rand_weight(1'b1));
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Waits until every item went out and every result came back, then lets the block settle.
    task automatic settle();
        do @(posedge i_clk);
        while (vert_pending_q.size() != 0 || vert_if.valid || clip_expect_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly closed polygons with random corners; some noise with random last flags.
    task automatic random_polygons(input int n_items);
        int count, size, k;
        bit noise;
        count = 0;
        while (count < n_items) begin
            noise = ($urandom_range(99) < 15);
            if (noise)
                size = $urandom_range(4, 1);
            else if ($urandom_range(99) < 20)
                size = $urandom_range(2, 1);
            else
                size = $urandom_range(6, 3);
            for (k = 0; k < size; k++)
                push_vert(rand_coord(), rand_coord(),
                          noise ? ($urandom_range(4) == 0) : (k == size - 1));
            count += size;
        end
    endtask

    initial begin : stimulus
        int ph;
        bit wide;
        vert_if.valid       = 1'b0;
        vert_if.vert_x      = '0;
        vert_if.vert_y      = '0;
        vert_if.last_vertex = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = '0;
        cfg_if.data         = '0;
        res_if.ready        = 1'b0;
        i_rst_n             = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset sites: the power difference is zero everywhere, so every vertex is inside.
        push_vert(C_MIN, C_MIN, 1'b0);
        push_vert(C_MAX, C_MIN, 1'b0);
        push_vert(C_MAX, C_MAX, 1'b0);
        push_vert(C_MIN, C_MAX, 1'b1);
        push_vert('0, '0, 1'b1);
        settle();

        // Bisector on x = 0, inside to the left; spare indexes must be ignored.
        load_sites(-C_HALF, '0, '0, C_HALF, '0, '0, 1'b1);
        push_vert(-C_ONE, -C_ONE, 1'b0);
        push_vert(C_ONE, -C_ONE, 1'b0);
        push_vert(C_ONE, C_ONE, 1'b0);
        push_vert(-C_ONE, C_ONE, 1'b1);
        // A lone vertex outside gives the empty end marker.
        push_vert(C_ONE, '0, 1'b1);
        // A polygon wholly outside does too.
        push_vert(C_HALF, '0, 1'b0);
        push_vert(C_MAX, C_MIN, 1'b0);
        push_vert(C_MAX, C_MAX, 1'b1);
        // Vertices exactly on the bisector count as inside.
        push_vert('0, -C_ONE, 1'b0);
        push_vert(C_ONE, '0, 1'b0);
        push_vert('0, C_ONE, 1'b1);
        // Open a polygon and change the weights before it closes.
        push_vert(-C_ONE, -C_ONE, 1'b0);
        push_vert(C_ONE, -C_ONE, 1'b0);
        settle();

        // Extreme weights pull every new vertex inside; stored differences stay as they were.
        load_sites(-C_HALF, '0, W_MAX, C_HALF, '0, W_MIN, 1'b0);
        push_vert(C_ONE, C_ONE, 1'b0);
        push_vert(-C_ONE, C_ONE, 1'b1);
        settle();

        // Opposite extremes push everything outside.
        load_sites(C_MAX, C_MAX, W_MIN, C_MIN, C_MIN, W_MAX, 1'b0);
        push_vert('0, '0, 1'b0);
        push_vert(C_MAX, C_MIN, 1'b0);
        push_vert(C_MIN, C_MAX, 1'b1);

        // Random site settings, each with a batch of random polygons.
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            wide = (ph % 3 == 0);
            load_sites(rand_coord(), rand_coord(), rand_weight(wide),
                       rand_coord(), rand_coord(), rand_weight(wide), $urandom_range(2) == 0);
            calm = (ph == 5);
            random_polygons(PHASE_ITEMS);
            // Stall the output long enough for the queue to fill and the input to back up.
            if (ph == 2)
                hold_left = HOLD_CYCLES;
        end
        settle();

        $display("tb: %0d vertices, %0d closed polygons, %0d results checked, %0d register writes",
                 vert_count, poly_count, res_count, cfg_count);
        $display("tb: reset, directed and %0d random site settings, with idle gaps and a long stall",
                 RAND_PHASES);
        if (err_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin : watchdog
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("tb: done, errors");
        $finish;
    end

endmodule
